### src/tlnu_pkg.sv
// Shared widths, pipeline transaction types and helpers for the transform
// interpolation unit. No dependencies.
`default_nettype none

package tlnu_pkg;

	// Lane format and blend factor format
	localparam int LANE_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int T_W     = 17;
	localparam int TFRAC_W = 16;

	// Internal widths
	localparam int Q_W    = LANE_W + 2;
	localparam int PROD_W = 2 * LANE_W;
	localparam int DOT_W  = PROD_W + 2;
	localparam int M_W    = Q_W + T_W + 1;
	localparam int SQ_W   = PROD_W + 2;
	localparam int ROOT_W = SQ_W / 2;
	localparam int SREM_W = ROOT_W + 3;
	localparam int QUO_W  = FRAC_W + 1;
	localparam int NUM_W  = LANE_W + FRAC_W + 1;
	localparam int DREM_W = ROOT_W + 1;

	// Pipeline depth
	localparam int FRONT_STAGES = 8;
	localparam int SQRT_STEPS   = ROOT_W;
	localparam int DIV_STEPS    = QUO_W;
	localparam int PIPE_LAT     = FRONT_STAGES + SQRT_STEPS + DIV_STEPS + 2;

	localparam logic [T_W-1:0] T_ONE  = T_W'(1) << TFRAC_W;
	localparam logic [T_W-1:0] T_HALF = T_W'(1) << (TFRAC_W - 1);

	localparam logic signed [Q_W-1:0] LANE_MAX =
		{{(Q_W-LANE_W+1){1'b0}}, {(LANE_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] LANE_MIN =
		{{(Q_W-LANE_W+1){1'b1}}, {(LANE_W-1){1'b0}}};

	// Request codes
	localparam logic [1:0] REQ_POS   = 2'd0;
	localparam logic [1:0] REQ_SCALE = 2'd1;
	localparam logic [1:0] REQ_ROT   = 2'd2;
	localparam logic [1:0] REQ_NONE  = 2'd3;

	typedef logic [3:0][LANE_W-1:0] lanes_t;
	typedef logic [3:0][Q_W-1:0]    qlanes_t;

	// Data that rides along the whole back end
	typedef struct packed {
		logic       vld;
		logic [1:0] req;
		qlanes_t    q;
	} side_t;

	// One square-root step transaction
	typedef struct packed {
		side_t             side;
		logic [SQ_W-1:0]   x;
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	// One division step transaction, four lanes over a shared divisor
	typedef struct packed {
		side_t                   side;
		logic [ROOT_W-1:0]       den;
		logic [3:0][DREM_W-1:0]  rem;
		logic [3:0][QUO_W-1:0]   nlow;
		logic [3:0][QUO_W-1:0]   quo;
	} div_t;

	// Magnitude of a blended lane; it never exceeds 2^(LANE_W-1)
	function automatic logic [LANE_W-1:0] mag_q(input logic [Q_W-1:0] v);
		logic [Q_W-1:0] m;
		m = v[Q_W-1] ? (~v + Q_W'(1)) : v;
		return m[LANE_W-1:0];
	endfunction

endpackage

`default_nettype wire

### src/tlnu_sqrt_cell.sv
// One cell of the square-root chain: resolves one root bit per cycle.
// Depends on tlnu_pkg.
`default_nettype none

module tlnu_sqrt_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tlnu_pkg::sqrt_t din,
	output tlnu_pkg::sqrt_t      dout
);
	import tlnu_pkg::*;

	logic              vld_q;
	sqrt_t             pay_q;
	sqrt_t             nxt;
	logic [SREM_W-1:0] rem2;
	logic [ROOT_W-1:0] root2;
	logic [SREM_W-1:0] trial;

	// Bring down the next bit pair and try the next root bit
	always_comb begin
		nxt   = din;
		rem2  = {din.rem[SREM_W-3:0], din.x[SQ_W-1 -: 2]};
		root2 = {din.root[ROOT_W-2:0], 1'b0};
		trial = {{(SREM_W-ROOT_W-1){1'b0}}, root2, 1'b1};
		nxt.x = {din.x[SQ_W-3:0], 2'b00};
		if (rem2 >= trial) begin
			nxt.rem  = rem2 - trial;
			nxt.root = root2 | ROOT_W'(1);
		end else begin
			nxt.rem  = rem2;
			nxt.root = root2;
		end
	end

	// Hold the valid flag under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.side.vld;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	always_comb begin
		dout          = pay_q;
		dout.side.vld = vld_q;
	end

endmodule

`default_nettype wire

### src/tlnu_div_cell.sv
// One cell of the division chain: one quotient bit for all four lanes.
// Depends on tlnu_pkg.
`default_nettype none

module tlnu_div_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tlnu_pkg::div_t din,
	output tlnu_pkg::div_t      dout
);
	import tlnu_pkg::*;

	logic              vld_q;
	div_t              pay_q;
	div_t              nxt;
	logic [DREM_W-1:0] r2;
	logic [DREM_W-1:0] dext;

	// Shift in one numerator bit per lane and subtract where it fits
	always_comb begin
		nxt  = din;
		r2   = '0;
		dext = {1'b0, din.den};
		for (int i = 0; i < 4; i++) begin
			r2 = {din.rem[i][DREM_W-2:0], din.nlow[i][QUO_W-1]};
			nxt.nlow[i] = {din.nlow[i][QUO_W-2:0], 1'b0};
			if (r2 >= dext) begin
				nxt.rem[i] = r2 - dext;
				nxt.quo[i] = {din.quo[i][QUO_W-2:0], 1'b1};
			end else begin
				nxt.rem[i] = r2;
				nxt.quo[i] = {din.quo[i][QUO_W-2:0], 1'b0};
			end
		end
	end

	// Hold the valid flag under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.side.vld;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	always_comb begin
		dout          = pay_q;
		dout.side.vld = vld_q;
	end

endmodule

`default_nettype wire

### src/tlnu_blend.sv
// Front end: dot product, hemisphere flip, lane blend and sum of squares,
// eight register stages. Depends on tlnu_pkg.
`default_nettype none

module tlnu_blend (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_vld,
	input  wire logic [1:0]                  in_req,
	input  wire logic [tlnu_pkg::T_W-1:0]    in_t,
	input  wire tlnu_pkg::lanes_t            in_a,
	input  wire tlnu_pkg::lanes_t            in_b,
	output tlnu_pkg::side_t                  side,
	output logic [tlnu_pkg::SQ_W-1:0]        sumsq
);
	import tlnu_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [1:0] req_s1, req_s2, req_s3, req_s4, req_s5, req_s6, req_s7, req_s8;
	logic [T_W-1:0] t_s1, t_s2, t_s3, t_s4;
	lanes_t a_s1, a_s2, a_s3, a_s4, a_s5;
	lanes_t b_s1, b_s2, b_s3;
	logic [3:0][PROD_W-1:0] p_s2;
	logic neg_s3;
	logic [3:0][Q_W-1:0] d_s4;
	logic [3:0][M_W-1:0] m_s5;
	qlanes_t q_s6, q_s7, q_s8;
	logic [3:0][PROD_W-1:0] sq_s7;
	logic [SQ_W-1:0] sum_s8;

	logic [T_W-1:0] t_clamp;
	logic signed [DOT_W-1:0] dot;
	logic [3:0][Q_W-1:0] d_nxt;
	logic [3:0][M_W-1:0] m_nxt;
	qlanes_t q_nxt;
	logic [3:0][PROD_W-1:0] sq_nxt;
	logic [SQ_W-1:0] sum_nxt;

	// Clamp the blend factor to one
	assign t_clamp = (in_t > T_ONE) ? T_ONE : in_t;

	// Sum the four lane products; flip b on a rotation request when the dot is negative
	always_comb begin
		dot = '0;
		for (int i = 0; i < 4; i++) begin
			dot = dot + DOT_W'($signed(p_s2[i]));
		end
	end

	// Lane difference against the possibly flipped end vector
	always_comb begin
		logic signed [Q_W-1:0] ax;
		logic signed [Q_W-1:0] bx;
		for (int i = 0; i < 4; i++) begin
			ax = Q_W'($signed(a_s3[i]));
			bx = Q_W'($signed(b_s3[i]));
			d_nxt[i] = (neg_s3 ? -bx : bx) - ax;
		end
	end

	// Scale the difference by t
	always_comb begin
		logic signed [M_W-1:0] mp;
		for (int i = 0; i < 4; i++) begin
			mp = $signed(d_s4[i]) * $signed({1'b0, t_s4});
			m_nxt[i] = mp;
		end
	end

	// Round half up and add the start lane
	always_comb begin
		logic signed [M_W-1:0] rnd;
		logic signed [M_W-1:0] sh;
		for (int i = 0; i < 4; i++) begin
			rnd = $signed(m_s5[i]) + $signed(M_W'(T_HALF));
			sh  = rnd >>> TFRAC_W;
			q_nxt[i] = Q_W'($signed(a_s5[i])) + sh[Q_W-1:0];
		end
	end

	// Square each lane magnitude
	always_comb begin
		logic [LANE_W-1:0] mg;
		for (int i = 0; i < 4; i++) begin
			mg = mag_q(q_s6[i]);
			sq_nxt[i] = PROD_W'(mg) * PROD_W'(mg);
		end
	end

	// Sum of squares
	always_comb begin
		sum_nxt = '0;
		for (int i = 0; i < 4; i++) begin
			sum_nxt = sum_nxt + SQ_W'(sq_s7[i]);
		end
	end

	// Hold stage valid flags under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Advance the payload one stage per cycle
	always_ff @(posedge clk) begin
		req_s1 <= in_req;
		t_s1   <= t_clamp;
		a_s1   <= in_a;
		b_s1   <= in_b;

		req_s2 <= req_s1;
		t_s2   <= t_s1;
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		for (int i = 0; i < 4; i++) begin
			p_s2[i] <= PROD_W'($signed(a_s1[i]) * $signed(b_s1[i]));
		end

		req_s3 <= req_s2;
		t_s3   <= t_s2;
		a_s3   <= a_s2;
		b_s3   <= b_s2;
		neg_s3 <= (req_s2 == REQ_ROT) && dot[DOT_W-1];

		req_s4 <= req_s3;
		t_s4   <= t_s3;
		a_s4   <= a_s3;
		d_s4   <= d_nxt;

		req_s5 <= req_s4;
		a_s5   <= a_s4;
		m_s5   <= m_nxt;

		req_s6 <= req_s5;
		q_s6   <= q_nxt;

		req_s7 <= req_s6;
		q_s7   <= q_s6;
		sq_s7  <= sq_nxt;

		req_s8 <= req_s7;
		q_s8   <= q_s7;
		sum_s8 <= sum_nxt;
	end

	assign side.vld = v_s8;
	assign side.req = req_s8;
	assign side.q   = q_s8;
	assign sumsq    = sum_s8;

endmodule

`default_nettype wire

### src/transform_lerp_nlerp_unit.sv
// Top level of the transform interpolation unit: front end, square-root
// and division cell chains, output register. Depends on tlnu_pkg,
// tlnu_blend, tlnu_sqrt_cell and tlnu_div_cell.
// Throughput: one transaction per cycle.
// The rate is set by the chain of 33 root cells and 17 quotient cells, one
// bit per cell per cycle; busy is always low. arst_n clears all valid flags.
`default_nettype none

module transform_lerp_nlerp_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [16:0] blend,
	input  wire logic [31:0] first_c0,
	input  wire logic [31:0] first_c1,
	input  wire logic [31:0] first_c2,
	input  wire logic [31:0] first_c3,
	input  wire logic [31:0] second_c0,
	input  wire logic [31:0] second_c1,
	input  wire logic [31:0] second_c2,
	input  wire logic [31:0] second_c3,
	output logic             done,
	output logic [31:0]      out_c0,
	output logic [31:0]      out_c1,
	output logic [31:0]      out_c2,
	output logic [31:0]      out_c3,
	output logic             saturated
);
	import tlnu_pkg::*;

	lanes_t          a_in;
	lanes_t          b_in;
	side_t           fe_side;
	logic [SQ_W-1:0] fe_sum;
	sqrt_t           sq_c [SQRT_STEPS+1];
	div_t            dv_c [DIV_STEPS+1];
	logic            dp_vld_q;
	div_t            dp_q;
	div_t            dp_nxt;
	div_t            last;
	lanes_t          res;
	logic            sat_nxt;
	logic            done_q;
	lanes_t          out_q;
	logic            sat_q;
	logic [1:0]      out_req_q;

	// Never stall
	assign busy = 1'b0;

	assign a_in = {first_c3, first_c2, first_c1, first_c0};
	assign b_in = {second_c3, second_c2, second_c1, second_c0};

	tlnu_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start),
		.in_req (req_type),
		.in_t   (blend),
		.in_a   (a_in),
		.in_b   (b_in),
		.side   (fe_side),
		.sumsq  (fe_sum)
	);

	// Seed the root chain
	assign sq_c[0] = '{side: fe_side, x: fe_sum, rem: '0, root: '0};

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		tlnu_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (sq_c[k]),
			.dout   (sq_c[k+1])
		);
	end

	// Build numerators: |q| scaled plus half the length for rounding
	always_comb begin
		logic [NUM_W-1:0] n;
		dp_nxt      = '0;
		dp_nxt.side = sq_c[SQRT_STEPS].side;
		dp_nxt.den  = sq_c[SQRT_STEPS].root;
		for (int i = 0; i < 4; i++) begin
			n = (NUM_W'(mag_q(sq_c[SQRT_STEPS].side.q[i])) << FRAC_W)
				+ NUM_W'(sq_c[SQRT_STEPS].root >> 1);
			dp_nxt.rem[i]  = DREM_W'(n[NUM_W-1:QUO_W]);
			dp_nxt.nlow[i] = n[QUO_W-1:0];
			dp_nxt.quo[i]  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_vld_q <= 1'b0;
		end else begin
			dp_vld_q <= sq_c[SQRT_STEPS].side.vld;
		end
	end

	always_ff @(posedge clk) begin
		dp_q <= dp_nxt;
	end

	// Seed the quotient chain with the reset-clean valid flag
	assign dv_c[0] = '{
		side: '{vld: dp_vld_q, req: dp_q.side.req, q: dp_q.side.q},
		den: dp_q.den, rem: dp_q.rem, nlow: dp_q.nlow, quo: dp_q.quo};

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		tlnu_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (dv_c[k]),
			.dout   (dv_c[k+1])
		);
	end

	assign last = dv_c[DIV_STEPS];

	// Select the lane result and clip it to the lane range
	always_comb begin
		logic signed [Q_W-1:0] v;
		logic signed [Q_W-1:0] qv;
		logic signed [Q_W-1:0] qq;
		sat_nxt = 1'b0;
		res     = '0;
		for (int i = 0; i < 4; i++) begin
			qv = $signed(last.side.q[i]);
			qq = $signed(Q_W'(last.quo[i]));
			case (last.side.req)
				REQ_POS, REQ_SCALE: begin
					v = (i < 3) ? qv : '0;
				end
				REQ_ROT: begin
					if (last.den == '0) begin
						v = qv;
					end else begin
						v = qv[Q_W-1] ? -qq : qq;
					end
				end
				default: begin
					v = '0;
				end
			endcase
			if (v > LANE_MAX) begin
				sat_nxt = 1'b1;
				res[i]  = LANE_MAX[LANE_W-1:0];
			end else if (v < LANE_MIN) begin
				sat_nxt = 1'b1;
				res[i]  = LANE_MIN[LANE_W-1:0];
			end else begin
				res[i] = v[LANE_W-1:0];
			end
		end
	end

	// Output register: one strobe per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.side.vld;
		end
	end

	always_ff @(posedge clk) begin
		out_q     <= res;
		sat_q     <= sat_nxt;
		out_req_q <= last.side.req;
	end

	assign done      = done_q;
	assign out_c0    = out_q[0];
	assign out_c1    = out_q[1];
	assign out_c2    = out_q[2];
	assign out_c3    = out_q[3];
	assign saturated = sat_q;

	// Every accepted transaction comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##PIPE_LAT done)
		else $error("transaction lost in pipeline");

	// A normalized quaternion always fits the lane range
	a_rot_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_req_q == REQ_ROT |-> !saturated)
		else $error("rotation result saturated");

	// Linear requests leave lane 3 at zero
	a_lin_w: assert property (@(posedge clk) disable iff (!arst_n)
		done && (out_req_q == REQ_POS || out_req_q == REQ_SCALE) |-> out_c3 == '0)
		else $error("lane 3 nonzero for linear blend");

	// Unused selector yields an all-zero result
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_req_q == REQ_NONE |->
			out_c0 == '0 && out_c1 == '0 && out_c2 == '0 && out_c3 == '0 && !saturated)
		else $error("unused selector produced data");

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for transform_lerp_nlerp_unit: directed and random
// position, scale, rotation and unused-selector transactions against a
// behavioral predictor. Depends on tlnu_pkg and the unit's RTL.
`default_nettype none

module testbench;
	import tlnu_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int DRAIN_CYCLES = PIPE_LAT + 20;
	localparam longint LANE_HI = 64'sd2147483647;
	localparam longint LANE_LO = -64'sd2147483648;

	typedef struct {
		logic [3:0][31:0] lane;
		logic             sat;
	} blend_out_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [16:0] blend;
	logic [31:0] first_c0, first_c1, first_c2, first_c3;
	logic [31:0] second_c0, second_c1, second_c2, second_c3;
	logic        done;
	logic [31:0] out_c0, out_c1, out_c2, out_c3;
	logic        saturated;

	blend_out_t pending_q[$];
	int         fail_count;
	bit         no_gaps;

	transform_lerp_nlerp_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .blend(blend),
		.first_c0(first_c0), .first_c1(first_c1),
		.first_c2(first_c2), .first_c3(first_c3),
		.second_c0(second_c0), .second_c1(second_c1),
		.second_c2(second_c2), .second_c3(second_c3),
		.done(done), .out_c0(out_c0), .out_c1(out_c1),
		.out_c2(out_c2), .out_c3(out_c3), .saturated(saturated)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop
	initial begin
		#(CLK_PERIOD * 300000);
		$display("FAIL transform_lerp_nlerp_unit");
		$finish;
	end

	// Round half up lerp of one lane
	function automatic longint lerp_lane(longint a, longint b, longint t);
		return a + (((b - a) * t + 64'sd32768) >>> 16);
	endfunction

	// Clip to the lane range and raise the flag
	function automatic longint clip_lane(longint v, inout logic flag);
		if (v > LANE_HI) begin
			flag = 1'b1;
			return LANE_HI;
		end
		if (v < LANE_LO) begin
			flag = 1'b1;
			return LANE_LO;
		end
		return v;
	endfunction

	// Floor square root of a 66-bit value, two bits per step
	function automatic logic [63:0] floor_root(logic [65:0] x);
		logic [67:0] rem;
		logic [67:0] root;
		logic [67:0] trial;
		rem = '0;
		root = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | 68'(x[2*i +: 2]);
			root = root << 1;
			trial = (root << 1) | 68'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = root | 68'd1;
			end
		end
		return root[63:0];
	endfunction

	// Predict one transaction's result
	function automatic blend_out_t predict_blend(logic [1:0] req, logic [16:0] t_raw,
			logic [3:0][31:0] fa, logic [3:0][31:0] fb);
		blend_out_t r;
		longint a[4], b[4], q[4];
		longint t, v;
		logic signed [65:0] dot;
		logic [65:0] ssum;
		logic [63:0] m, len, num;
		logic flag;
		flag = 1'b0;
		r.lane = '0;
		t = (t_raw > 17'd65536) ? 64'sd65536 : longint'(t_raw);
		for (int i = 0; i < 4; i++) begin
			a[i] = longint'($signed(fa[i]));
			b[i] = longint'($signed(fb[i]));
		end
		if (req == REQ_POS || req == REQ_SCALE) begin
			for (int i = 0; i < 3; i++)
				r.lane[i] = 32'(clip_lane(lerp_lane(a[i], b[i], t), flag));
		end else if (req == REQ_ROT) begin
			dot = '0;
			for (int i = 0; i < 4; i++)
				dot = dot + 66'(a[i] * b[i]);
			ssum = '0;
			for (int i = 0; i < 4; i++) begin
				q[i] = lerp_lane(a[i], (dot < 0) ? -b[i] : b[i], t);
				m = (q[i] < 0) ? 64'(-q[i]) : 64'(q[i]);
				ssum = ssum + 66'(m * m);
			end
			len = floor_root(ssum);
			for (int i = 0; i < 4; i++) begin
				if (len == 0) begin
					r.lane[i] = 32'(clip_lane(q[i], flag));
				end else begin
					m = (q[i] < 0) ? 64'(-q[i]) : 64'(q[i]);
					num = m << FRAC_W;
					v = longint'((num + len / 2) / len);
					r.lane[i] = 32'(clip_lane((q[i] < 0) ? -v : v, flag));
				end
			end
		end
		r.sat = flag;
		return r;
	endfunction

	// Send one transaction; returns just after the edge that accepted it
	task automatic send_item(logic [1:0] req, logic [16:0] t,
			logic [3:0][31:0] fa, logic [3:0][31:0] fb);
		while (!no_gaps && $urandom_range(99) < 24) begin
			start <= 1'b0;
			req_type <= 2'($urandom);
			blend <= 17'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		blend <= t;
		first_c0 <= fa[0];
		first_c1 <= fa[1];
		first_c2 <= fa[2];
		first_c3 <= fa[3];
		second_c0 <= fb[0];
		second_c1 <= fb[1];
		second_c2 <= fb[2];
		second_c3 <= fb[3];
		@(negedge clk);
		while (busy) @(negedge clk);
		pending_q.insert(pending_q.size(), predict_blend(req, t, fa, fb));
		@(posedge clk);
	endtask

	// Check each result against the oldest prediction
	always @(negedge clk) begin
		blend_out_t exp_r;
		logic [3:0][31:0] got;
		if (arst_n && done) begin
			got = {out_c3, out_c2, out_c1, out_c0};
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result lanes %h sat %b", $time, got, saturated);
				fail_count++;
			end else begin
				exp_r = pending_q.pop_front();
				for (int i = 0; i < 4; i++)
					if (got[i] !== exp_r.lane[i]) begin
						$display("%0t: out_c%0d expected %h actual %h", $time, i,
							exp_r.lane[i], got[i]);
						fail_count++;
					end
				if (saturated !== exp_r.sat) begin
					$display("%0t: saturated expected %b actual %b", $time,
						exp_r.sat, saturated);
					fail_count++;
				end
			end
		end
	end

	// Random lane value: full range, small, or an extreme
	function automatic logic [31:0] rand_lane();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(int'($urandom_range(131072)) - 65536);
			3: return 32'(int'($urandom_range(2000)) - 1000);
			4: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [16:0] rand_blend();
		case ($urandom_range(7))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom);
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	// Lerp extremes, blend clamp, ignored lane 3 and the unused selector
	task automatic test_lerp_directed();
		logic [3:0][31:0] mx, mn, z;
		mx = {4{32'h7fff_ffff}};
		mn = {4{32'h8000_0000}};
		z = '0;
		send_item(REQ_POS, 17'd0, mx, mn);
		send_item(REQ_POS, 17'd65536, mx, mn);
		send_item(REQ_SCALE, 17'd32768, mn, mx);
		send_item(REQ_SCALE, 17'h1ffff, mn, mx);
		send_item(REQ_POS, 17'd65537, z, mx);
		send_item(REQ_POS, 17'd1, {32'h1234_5678, 32'd3, 32'hffff_fffd, 32'd1},
			{32'hfedc_ba98, 32'd4, 32'hffff_fffc, 32'd9});
		send_item(REQ_SCALE, 17'd65535, mn, mx);
		send_item(REQ_NONE, 17'd40000, mx, mn);
		send_item(REQ_NONE, 17'd0, z, z);
	endtask

	// Rotation: flipped hemisphere, zero dot, zero length, extremes
	task automatic test_rot_directed();
		logic [3:0][31:0] z;
		z = '0;
		send_item(REQ_ROT, 17'd32768, {32'd0, 32'd0, 32'd0, 32'h0001_0000},
			{32'd0, 32'd0, 32'h0001_0000, 32'd0});
		send_item(REQ_ROT, 17'd32768, {32'd0, 32'd0, 32'd0, 32'h0001_0000},
			{32'd0, 32'd0, 32'd0, 32'hffff_0000});
		send_item(REQ_ROT, 17'd20000, {32'h0000_b505, 32'd0, 32'd0, 32'h0000_b505},
			{32'hffff_4afb, 32'd0, 32'd0, 32'hffff_4afb});
		send_item(REQ_ROT, 17'd12345, z, z);
		send_item(REQ_ROT, 17'd65536, {4{32'h8000_0000}}, {4{32'h7fff_ffff}});
		send_item(REQ_ROT, 17'd0, {4{32'h7fff_ffff}}, {4{32'h7fff_ffff}});
		send_item(REQ_ROT, 17'h1ffff, {4{32'h8000_0000}}, {4{32'h8000_0000}});
		send_item(REQ_ROT, 17'd32768, {32'd1, 32'd0, 32'd0, 32'd0}, z);
		send_item(REQ_ROT, 17'd65536, {32'd7, 32'hffff_fffd, 32'd2, 32'd5},
			{32'hfff0_0000, 32'd1, 32'hffff_ffff, 32'd3});
	endtask

	// Random traffic with one stretch of back-to-back transactions
	task automatic test_random_traffic();
		logic [3:0][31:0] fa, fb;
		logic [1:0] req;
		for (int n = 0; n < 1400; n++) begin
			no_gaps = (n >= 500 && n < 700);
			req = ($urandom_range(19) == 0) ? REQ_NONE : 2'($urandom_range(2));
			for (int i = 0; i < 4; i++) begin
				fa[i] = rand_lane();
				fb[i] = ($urandom_range(4) == 0) ? -fa[i] : rand_lane();
			end
			send_item(req, rand_blend(), fa, fb);
		end
		no_gaps = 1'b0;
	endtask

	// Sequence the tests and report
	initial begin
		fail_count = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = '0;
		blend = '0;
		{first_c0, first_c1, first_c2, first_c3} = '0;
		{second_c0, second_c1, second_c2, second_c3} = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lerp_directed();
		test_rot_directed();
		test_random_traffic();
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS transform_lerp_nlerp_unit");
		else
			$display("FAIL transform_lerp_nlerp_unit");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
src/tlnu_pkg.sv
src/tlnu_sqrt_cell.sv
src/tlnu_div_cell.sv
src/tlnu_blend.sv
src/transform_lerp_nlerp_unit.sv
sim/testbench.sv
